// ----- rtl/firpt_pkg.sv -----
// ----------------------------------------------------------------------------
// FIR filter, programmable taps: shared package
// Sizes, the default bandpass table and the controller/datapath interface.
// ----------------------------------------------------------------------------
package firpt_pkg;

  localparam int MAX_TAPS     = 512;
  localparam int TAP_W        = $clog2(MAX_TAPS);
  localparam int FILL_W       = TAP_W + 1;
  localparam int SAMPLE_BITS  = 16;
  localparam int FRAC_BITS    = SAMPLE_BITS - 1;
  localparam int PROD_W       = 2 * SAMPLE_BITS;
  localparam int ACC_BITS     = 48;
  localparam int RND_W        = ACC_BITS - FRAC_BITS + 1;
  localparam int TAP_CNT_W    = 10;
  localparam int DEFAULT_TAPS = 63;
  localparam int HALF_TAPS    = 32;

  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = TAP_CNT_W'(DEFAULT_TAPS);

  // input word operation
  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_COEF   = 1'b1
  } fir_op_t;

  // first half of the symmetric default bandpass, Q1.15
  localparam logic signed [SAMPLE_BITS-1:0] BANDPASS_HALF [HALF_TAPS] = '{
    -16'sd1468,  16'sd1058,   16'sd594,   16'sd287,   16'sd186,   16'sd284,
     16'sd485,   16'sd613,    16'sd495,   16'sd90,   -16'sd435,  -16'sd762,
    -16'sd615,   16'sd21,     16'sd821,   16'sd1269,  16'sd982,   16'sd9,
    -16'sd1132, -16'sd1721,  -16'sd1296,  16'sd1,     16'sd1445,  16'sd2136,
     16'sd1570,  16'sd0,     -16'sd1666, -16'sd2413, -16'sd1735, -16'sd2,
     16'sd1770,  16'sd2512
  };

  // controller to datapath
  typedef struct packed {
    logic preload_we;  // write the default tap at the index counter
    logic coef_we;     // store the coefficient word on the input
    logic smp_ld;      // take the sample word, clear the accumulator
    logic idx_clr;
    logic idx_inc;
    logic issue;       // read one tap pair into the MAC pipeline
    logic done;        // load the result register, advance the write pointer
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_at_end;   // index counter on the last memory entry
    logic idx_at_last;  // index counter on the last tap in use
    logic pipe_empty;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [SAMPLE_BITS-1:0] default_coef(
    input logic [TAP_W-1:0] idx
  );
    logic [TAP_W-1:0] h;
    h = '0;
    if (32'(idx) >= DEFAULT_TAPS) begin
      return '0;
    end
    if (32'(idx) < HALF_TAPS) begin
      h = idx;
    end else begin
      h = TAP_W'(DEFAULT_TAPS - 1) - idx;
    end
    return BANDPASS_HALF[h[$clog2(HALF_TAPS)-1:0]];
  endfunction

endpackage

// ----- rtl/firpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// FIR filter, programmable taps: controller
// Sequences the coefficient preload, item acceptance, the tap walk and drain.
// ----------------------------------------------------------------------------
module firpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  input  firpt_pkg::dp_sts_t sts,
  output firpt_pkg::dp_cmd_t cmd
);
  import firpt_pkg::*;

  localparam logic [1:0] S_PRELOAD = 2'd0;
  localparam logic [1:0] S_IDLE    = 2'd1;
  localparam logic [1:0] S_MAC     = 2'd2;
  localparam logic [1:0] S_DRAIN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_PRELOAD: begin
        cmd.preload_we = 1'b1;
        if (sts.idx_at_end) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_FILTER) begin
            cmd.smp_ld  = 1'b1;
            cmd.idx_clr = 1'b1;
            state_nxt   = S_MAC;
          end else begin
            cmd.coef_we = 1'b1;
          end
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (sts.idx_at_last) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        // hold until the last product is summed and the output is free
        if (sts.pipe_empty && sts.out_free) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_PRELOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_PRELOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/firpt_dp.sv -----
// ----------------------------------------------------------------------------
// FIR filter, programmable taps: datapath
// Delay and coefficient memories, one shared MAC, rounding and output word.
// ----------------------------------------------------------------------------
module firpt_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  firpt_pkg::dp_cmd_t                      cmd,
  output firpt_pkg::dp_sts_t                      sts,
  input  logic                                    cfg_we,
  input  logic [firpt_pkg::TAP_CNT_W-1:0]         cfg_wdata,
  input  logic signed [firpt_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic [firpt_pkg::TAP_W-1:0]             in_coef_index,
  input  logic signed [firpt_pkg::SAMPLE_BITS-1:0] in_coef_value,
  input  logic                                    in_block_end,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [firpt_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                    out_block_end
);
  import firpt_pkg::*;

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] dly_mem  [MAX_TAPS];

  logic [TAP_CNT_W-1:0]          tap_count_r;
  logic [TAP_W-1:0]              idx_r;
  logic [TAP_W-1:0]              wp_r;
  logic [FILL_W-1:0]             fill_r;
  logic                          be_r;
  logic                          v1_r;
  logic                          ok1_r;
  logic signed [SAMPLE_BITS-1:0] coef_q_r;
  logic signed [SAMPLE_BITS-1:0] smp_q_r;
  logic                          v2_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_BITS-1:0]    acc_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_be_r;

  logic [TAP_W-1:0]              taps_m1;
  logic [TAP_W-1:0]              rd_addr;
  logic [TAP_W-1:0]              coef_waddr;
  logic signed [SAMPLE_BITS-1:0] coef_wdata;
  logic                          coef_wen;
  logic signed [ACC_BITS-1:0]    acc_shr;
  logic signed [RND_W-1:0]       rnd_sum;
  logic [RND_W-FRAC_BITS-1:0]    rnd_top;
  logic signed [SAMPLE_BITS-1:0] result;

  // zero taps acts as one, anything past the memory as the full depth
  always_comb begin
    if (tap_count_r <= TAP_CNT_W'(1)) begin
      taps_m1 = '0;
    end else if (32'(tap_count_r) > MAX_TAPS) begin
      taps_m1 = TAP_W'(MAX_TAPS - 1);
    end else begin
      taps_m1 = TAP_W'(tap_count_r - TAP_CNT_W'(1));
    end
  end

  assign rd_addr = wp_r - idx_r;

  assign sts.idx_at_end  = (idx_r == TAP_W'(MAX_TAPS - 1));
  assign sts.idx_at_last = (idx_r == taps_m1);
  assign sts.pipe_empty  = !v1_r && !v2_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign coef_wen   = cmd.preload_we || cmd.coef_we;
  assign coef_waddr = cmd.preload_we ? idx_r : in_coef_index;
  assign coef_wdata = cmd.preload_we ? default_coef(idx_r) : in_coef_value;

  // round half up, then saturate to the sample range
  always_comb begin
    acc_shr = acc_r >>> FRAC_BITS;
    rnd_sum = RND_W'(acc_shr) + RND_W'({1'b0, acc_r[FRAC_BITS-1]});
    rnd_top = rnd_sum[RND_W-1:FRAC_BITS];
    if ((&rnd_top) || !(|rnd_top)) begin
      result = rnd_sum[SAMPLE_BITS-1:0];
    end else if (rnd_sum[RND_W-1]) begin
      result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (coef_wen) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    if (cmd.issue) begin
      coef_q_r <= coef_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_ld) begin
      dly_mem[wp_r] <= in_sample_in;
    end
    if (cmd.issue) begin
      smp_q_r <= dly_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_ld) begin
      be_r <= in_block_end;
    end
    // drop taps that reach back past the first sample since reset
    prod_r <= ok1_r ? PROD_W'(coef_q_r * smp_q_r) : '0;
    if (cmd.smp_ld) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_BITS'(prod_r);
    end
    if (cmd.done) begin
      out_sample_r <= result;
      out_be_r     <= be_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_CNT_RESET;
      idx_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      v1_r        <= 1'b0;
      ok1_r       <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + TAP_W'(1);
      end
      if (cmd.smp_ld && (32'(fill_r) < MAX_TAPS)) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (cmd.done) begin
        wp_r <= wp_r + TAP_W'(1);
      end
      v1_r  <= cmd.issue;
      ok1_r <= cmd.issue && (FILL_W'(idx_r) < fill_r);
      v2_r  <= v1_r;
      if (cmd.done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_block_end  = out_be_r;

endmodule

// ----- rtl/fir_filter_programmable_taps_core.sv -----
// ----------------------------------------------------------------------------
// FIR filter, programmable taps: top level
// Direct-form mono FIR, up to 512 Q1.15 taps, one shared multiply-accumulate.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | input     | in_valid / in_stall  | op, sample_in, coef_index,
//           |           |                      | coef_value, block_end
//  out_     | output    | out_valid / out_stall| sample_out, out_block_end
//  cfg_     | input     | cfg_we               | cfg_wdata (tap count)
//
// After a sample word is accepted the input stalls while the controller walks
// the taps in use (a tap count of zero walks one tap, above 512 walks 512):
// one memory read pair per tap through the single MAC, then pipeline drain
// and rounding, then the idle state that takes the next word. A coefficient
// word is written in the idle state and leaves the input open. After reset a
// preload pass writes the default coefficients; in_stall is high throughout.
// A waiting result does not block the next input word; only the completion
// of the following sample waits for the output register.
// ----------------------------------------------------------------------------
module fir_filter_programmable_taps_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_op,
  input  logic signed [firpt_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic [firpt_pkg::TAP_W-1:0]             in_coef_index,
  input  logic signed [firpt_pkg::SAMPLE_BITS-1:0] in_coef_value,
  input  logic                                    in_block_end,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [firpt_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                    out_block_end,
  input  logic                                    cfg_we,
  input  logic [firpt_pkg::TAP_CNT_W-1:0]         cfg_wdata
);
  import firpt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  firpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  firpt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_sample_in   (in_sample_in),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .in_block_end   (in_block_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_block_end  (out_block_end)
  );

  // coefficient preload follows every reset
  a_preload_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during coefficient preload");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_op |=> in_stall)
    else $error("sample word did not start the tap walk");

  a_coef_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op |=> !in_stall)
    else $error("coefficient word held the input");

  a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |-> sts.pipe_empty && !cmd.issue)
    else $error("result loaded with products still in flight");

endmodule
